/* hdl/txtcon_pkg.sv */
// Shared types and constants for the text console cursor controller.
// Used by the channel interfaces, the cursor logic and the top level.
// No dependencies.
package txtcon_pkg;

    // Default geometry of the text screen.
    localparam int COLS_DEF   = 80;
    localparam int ROWS_DEF   = 30;
    localparam int CELL_W_DEF = 8;
    localparam int CELL_H_DEF = 16;

    // Field widths of the channels.
    localparam int CHAR_W  = 8;
    localparam int CMD_W   = 2;
    localparam int POSX_W  = 10;
    localparam int POSY_W  = 9;
    localparam int COLOR_W = 24;
    localparam int CFG_IDX_W = 1;

    // Tab advances by this many cells before alignment.
    localparam int TAB_CELLS = 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'd1;

    // Register reset values.
    localparam logic [COLOR_W-1:0] FG_COLOR_RST = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] BG_COLOR_RST = 24'h000000;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

    // One drawing command.
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [CHAR_W-1:0]  glyph_code;
        logic [POSX_W-1:0]  pos_x;
        logic [POSY_W-1:0]  pos_y;
        logic [COLOR_W-1:0] paint_color;
        logic               last;
    } result_t;

    // Commands produced by one character, in output order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

/* hdl/txtcon_if.sv */
// Valid/ready channel interfaces for characters in and commands out.
// Depends on txtcon_pkg for field widths.
interface txtcon_char_if;
    logic                            valid;
    logic                            ready;
    logic [txtcon_pkg::CHAR_W-1:0]   char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface txtcon_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [txtcon_pkg::CMD_W-1:0]    command;
    logic [txtcon_pkg::CHAR_W-1:0]   glyph_code;
    logic [txtcon_pkg::POSX_W-1:0]   pos_x;
    logic [txtcon_pkg::POSY_W-1:0]   pos_y;
    logic [txtcon_pkg::COLOR_W-1:0]  paint_color;
    logic                            last;

    modport source (output valid, output command, output glyph_code, output pos_x,
                    output pos_y, output paint_color, output last, input ready);
    modport sink   (input valid, input command, input glyph_code, input pos_x,
                    input pos_y, input paint_color, input last, output ready);
endinterface

/* hdl/txtcon_cursor.sv */
// Cursor state, color registers and per-character command decode.
// Depends on txtcon_pkg.
module txtcon_cursor #(
    parameter int COLS   = txtcon_pkg::COLS_DEF,
    parameter int ROWS   = txtcon_pkg::ROWS_DEF,
    parameter int CELL_W = txtcon_pkg::CELL_W_DEF,
    parameter int CELL_H = txtcon_pkg::CELL_H_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [txtcon_pkg::CHAR_W-1:0]       char_code,
    input  logic                                cfg_we,
    input  logic [txtcon_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [txtcon_pkg::COLOR_W-1:0]      cfg_data,
    output txtcon_pkg::push_t                   push
);
    import txtcon_pkg::*;

    localparam int SCREEN_W = COLS * CELL_W;
    localparam int SCREEN_H = ROWS * CELL_H;
    localparam int TAB_W    = TAB_CELLS * CELL_W;
    localparam int XW       = $clog2(SCREEN_W + TAB_W);
    localparam int YW       = $clog2(SCREEN_H + CELL_H);
    localparam int CW_SH    = $clog2(CELL_W);

    logic [XW-1:0]      x_reg, x_next;
    logic [YW-1:0]      y_reg, y_next;
    logic [COLOR_W-1:0] fg_reg, bg_reg;

    logic [XW-1:0] x_step;
    logic [XW-1:0] x_tab;
    logic [YW-1:0] y_step;
    logic          prim_valid;
    logic          scroll;
    result_t       prim;
    result_t       scr;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= FG_COLOR_RST;
            bg_reg <= BG_COLOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FG_COLOR: fg_reg <= cfg_data;
                REG_BG_COLOR: bg_reg <= cfg_data;
                default:      fg_reg <= fg_reg;
            endcase
        end
    end

    // Tab target: advance by the tab width and align down to a cell.
    assign x_tab = ((x_reg + XW'(TAB_W)) >> CW_SH) << CW_SH;

    // Character decode, right edge wrap and bottom edge scroll.
    always_comb
    begin
        x_step     = x_reg;
        y_step     = y_reg;
        prim_valid = 1'b0;
        prim       = '0;
        scr        = '0;
        case (char_code) inside
            CH_BS:
            begin
                if (x_reg >= XW'(CELL_W + 1))
                begin
                    x_step           = x_reg - XW'(CELL_W);
                    prim_valid       = 1'b1;
                    prim.command     = CMD_CLEAR;
                    prim.pos_x       = POSX_W'(x_step);
                    prim.pos_y       = POSY_W'(y_reg);
                    prim.paint_color = bg_reg;
                end
            end
            CH_TAB:
            begin
                x_step = x_tab;
            end
            CH_CR:
            begin
                x_step = '0;
            end
            CH_LF:
            begin
                x_step = '0;
                y_step = y_reg + YW'(CELL_H);
            end
            [CH_PRINT_LO:CH_PRINT_HI]:
            begin
                prim_valid       = 1'b1;
                prim.command     = CMD_DRAW;
                prim.glyph_code  = char_code;
                prim.pos_x       = POSX_W'(x_reg);
                prim.pos_y       = POSY_W'(y_reg);
                prim.paint_color = fg_reg;
                x_step           = x_reg + XW'(CELL_W);
            end
            default:
            begin
                x_step = x_reg;
            end
        endcase

        // Wrap to the next text row at the right edge.
        x_next = x_step;
        y_next = y_step;
        if (x_step >= XW'(SCREEN_W))
        begin
            x_next = '0;
            y_next = y_step + YW'(CELL_H);
        end

        // Scroll and keep the cursor on the last row at the bottom edge.
        scroll = (y_next >= YW'(SCREEN_H));
        if (scroll)
        begin
            y_next = YW'(SCREEN_H - CELL_H);
        end

        scr.command     = CMD_SCROLL;
        scr.paint_color = bg_reg;
        scr.last        = 1'b1;
        prim.last       = !scroll;
    end

    // Commands in output order.
    always_comb
    begin
        push.count  = {1'b0, prim_valid} + {1'b0, scroll};
        push.first  = prim_valid ? prim : scr;
        push.second = scr;
        if (!accept)
        begin
            push.count = 2'd0;
        end
    end

    // Cursor state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else if (accept)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

endmodule

/* hdl/text_console_cursor_controller_top.sv */
// Text console cursor controller: a character stream in, drawing commands out.
// A new character is accepted in any cycle in which the four-entry command
// queue has room for two commands; its commands are decoded in the same cycle
// and written into the queue, which gives them out in order. The command
// channel gives one command per cycle while the receiver is ready, so a stream
// of characters that each cause one command runs at one character per cycle,
// and a character that causes two (a draw then a scroll) gives both in turn.
// Depends on txtcon_pkg, txtcon_if and txtcon_cursor.
module text_console_cursor_controller_top #(
    parameter int COLS   = txtcon_pkg::COLS_DEF,
    parameter int ROWS   = txtcon_pkg::ROWS_DEF,
    parameter int CELL_W = txtcon_pkg::CELL_W_DEF,
    parameter int CELL_H = txtcon_pkg::CELL_H_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    txtcon_char_if.sink                         char_stream,
    txtcon_cmd_if.source                        cmd_stream,
    input  logic                                cfg_we,
    input  logic [txtcon_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [txtcon_pkg::COLOR_W-1:0]      cfg_data
);
    import txtcon_pkg::*;

    localparam int QDEPTH = 4;
    localparam int PW     = $clog2(QDEPTH);

    result_t          queue_reg [QDEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             accept;
    logic             pop;
    push_t            push;
    result_t          head;

    // Room for two commands means a character transaction may start.
    assign char_stream.ready = (count_reg <= (PW+1)'(QDEPTH - 2));
    assign accept            = char_stream.valid && char_stream.ready;

    txtcon_cursor #(
        .COLS   (COLS),
        .ROWS   (ROWS),
        .CELL_W (CELL_W),
        .CELL_H (CELL_H)
    ) u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (char_stream.char_code),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    // Queue payload: up to two writes per cycle.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            queue_reg[wr_ptr_reg + PW'(1)] <= push.second;
        end
    end

    // Queue pointers and fill count.
    assign pop         = cmd_stream.valid && cmd_stream.ready;
    assign wr_ptr_next = wr_ptr_reg + PW'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign count_next  = count_reg + (PW+1)'(push.count) - (PW+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command transaction from the queue head.
    assign head                   = queue_reg[rd_ptr_reg];
    assign cmd_stream.valid       = (count_reg != '0);
    assign cmd_stream.command     = head.command;
    assign cmd_stream.glyph_code  = head.glyph_code;
    assign cmd_stream.pos_x       = head.pos_x;
    assign cmd_stream.pos_y       = head.pos_y;
    assign cmd_stream.paint_color = head.paint_color;
    assign cmd_stream.last        = head.last;

endmodule

/* tb/text_console_cursor_controller_top_tb.sv */
// Self-checking testbench for the text console cursor controller.
// Predicts the command stream of each character, checks every command transaction.
// Depends on txtcon_pkg, the txtcon_if interfaces and the controller top level.
`timescale 1ns / 100ps

module text_console_cursor_controller_top_tb;
    import txtcon_pkg::*;

    localparam int SCREEN_W     = COLS_DEF * CELL_W_DEF;
    localparam int SCREEN_H     = ROWS_DEF * CELL_H_DEF;
    localparam int PHASE_ITEMS  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_CYCLES = 150;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FG_COLOR;
    logic [COLOR_W-1:0]   cfg_data  = '0;

    txtcon_char_if char_ch ();
    txtcon_cmd_if  cmd_ch ();

    text_console_cursor_controller_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_ch),
        .cmd_stream  (cmd_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Characters waiting to be sent and commands the cursor logic must still give.
    logic [CHAR_W-1:0] pending_chars[$];
    result_t           predicted_cmds[$];

    // Own copy of the registers and the cursor.
    logic [COLOR_W-1:0] fg_shadow = FG_COLOR_RST;
    logic [COLOR_W-1:0] bg_shadow = BG_COLOR_RST;
    logic [POSX_W-1:0]  cur_x = '0;
    logic [POSY_W-1:0]  cur_y = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic stall_request = 1'b0;
    logic stall_done;
    int   stall_left;

    int chars_queued     = 0;
    int effective_queued = 0;
    int chars_accepted   = 0;
    int cmds_checked     = 0;
    int mismatches       = 0;
    int draw_count       = 0;
    int clear_count      = 0;
    int scroll_count     = 0;
    int twin_count       = 0;
    int cycle_count      = 0;

    // Clock.
    always #5 clk = ~clk;

    // Advance the cursor by one character and queue the commands it causes.
    task automatic advance_cursor(input logic [CHAR_W-1:0] ch);
        result_t cmds[2];
        int n;
        n = 0;
        if (ch == CH_BS) begin
            // Backspace only acts from the third cell on; at x = 8 nothing happens.
            if (cur_x >= CELL_W_DEF + 1) begin
                cur_x = POSX_W'(cur_x - CELL_W_DEF);
                cmds[n] = '{CMD_CLEAR, '0, cur_x, cur_y, bg_shadow, 1'b0};
                n++;
                clear_count++;
            end
        end
        else if (ch == CH_TAB) begin
            cur_x = POSX_W'((cur_x + TAB_CELLS * CELL_W_DEF) / CELL_W_DEF * CELL_W_DEF);
        end
        else if (ch == CH_CR) begin
            cur_x = '0;
        end
        else if (ch == CH_LF) begin
            cur_x = '0;
            cur_y = POSY_W'(cur_y + CELL_H_DEF);
        end
        else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
            cmds[n] = '{CMD_DRAW, ch, cur_x, cur_y, fg_shadow, 1'b0};
            n++;
            draw_count++;
            cur_x = POSX_W'(cur_x + CELL_W_DEF);
        end

        // Wrap at the right edge, scroll at the bottom edge.
        if (cur_x >= SCREEN_W) begin
            cur_x = '0;
            cur_y = POSY_W'(cur_y + CELL_H_DEF);
        end
        if (cur_y >= SCREEN_H) begin
            cmds[n] = '{CMD_SCROLL, '0, '0, '0, bg_shadow, 1'b0};
            n++;
            scroll_count++;
            cur_y = POSY_W'(SCREEN_H - CELL_H_DEF);
        end

        if (n > 0)
            cmds[n-1].last = 1'b1;
        if (n == 2)
            twin_count++;
        for (int i = 0; i < n; i++)
            predicted_cmds.push_back(cmds[i]);
    endtask

    // Queue one character; backspace, tab, CR, LF and printable codes count toward the phase size.
    task automatic queue_char(input logic [CHAR_W-1:0] ch);
        pending_chars.push_back(ch);
        chars_queued++;
        if (ch == CH_BS || ch == CH_TAB || ch == CH_CR || ch == CH_LF ||
            (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI))
            effective_queued++;
    endtask

    // Random text shaped like console output: long wrapping lines, short lines,
    // runs of line feeds, typing with corrections and some stray bytes.
    task automatic queue_text(input int count);
        int target;
        int kind;
        int len;
        int r;
        target = effective_queued + count;
        while (effective_queued < target) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                len = $urandom_range(100, 60);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(99);
                    if (r < 85)
                        queue_char(CHAR_W'($urandom_range(CH_PRINT_HI, CH_PRINT_LO)));
                    else if (r < 90)
                        queue_char(CH_TAB);
                    else if (r < 95)
                        queue_char(CH_BS);
                    else
                        queue_char(CHAR_W'($urandom_range(255)));
                end
                if ($urandom_range(1))
                    queue_char(CH_LF);
            end
            else if (kind < 65) begin
                len = $urandom_range(15);
                for (int i = 0; i < len; i++)
                    queue_char(CHAR_W'($urandom_range(CH_PRINT_HI, CH_PRINT_LO)));
                if ($urandom_range(3) == 0)
                    queue_char(CH_CR);
                queue_char(CH_LF);
            end
            else if (kind < 90) begin
                len = $urandom_range(20, 1);
                for (int i = 0; i < len; i++)
                    queue_char(CH_LF);
            end
            else if (kind < 96) begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++)
                    queue_char(CHAR_W'($urandom_range(CH_PRINT_HI, CH_PRINT_LO)));
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++)
                    queue_char(CH_BS);
            end
            else begin
                len = $urandom_range(4, 1);
                for (int i = 0; i < len; i++)
                    queue_char(CHAR_W'($urandom_range(255)));
            end
        end
    endtask

    // Wait until every character is taken and every command has come out.
    task automatic wait_drained();
        while (chars_accepted != chars_queued || predicted_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both color registers while the block is idle.
    task automatic write_colors(input logic [COLOR_W-1:0] fg,
                                input logic [COLOR_W-1:0] bg);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FG_COLOR;
        cfg_data  <= fg;
        @(posedge clk);
        cfg_index <= REG_BG_COLOR;
        cfg_data  <= bg;
        @(posedge clk);
        cfg_we    <= 1'b0;
        fg_shadow = fg;
        bg_shadow = bg;
    endtask

    // Compare one field of a command transaction.
    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Character driver: predicts on each accepted transaction, then offers the next.
    always @(posedge clk or negedge rst_n)
    begin : char_driver
        logic holding;
        if (!rst_n)
        begin
            char_ch.valid     <= 1'b0;
            char_ch.char_code <= '0;
        end
        else
        begin
            holding = char_ch.valid && !char_ch.ready;
            if (char_ch.valid && char_ch.ready)
            begin
                advance_cursor(char_ch.char_code);
                chars_accepted++;
            end
            if (!holding)
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    char_ch.valid     <= 1'b1;
                    char_ch.char_code <= pending_chars.pop_front();
                end
                else
                    char_ch.valid <= 1'b0;
            end
        end
    end

    // Command ready: random idling, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.ready <= 1'b0;
            stall_left   <= 0;
            stall_done   <= 1'b0;
        end
        else if (stall_request && !stall_done)
        begin
            stall_left   <= STALL_CYCLES;
            stall_done   <= 1'b1;
            cmd_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            cmd_ch.ready <= 1'b0;
        end
        else
            cmd_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Command monitor: each transaction against the oldest prediction.
    always @(posedge clk)
    begin : cmd_monitor
        result_t want;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            cmds_checked++;
            if (predicted_cmds.size() == 0)
            begin
                $display("%0t: unexpected command: expected none, got cmd %0d glyph 0x%0h",
                         $time, cmd_ch.command, cmd_ch.glyph_code);
                mismatches++;
            end
            else
            begin
                want = predicted_cmds.pop_front();
                check_field("command", want.command, cmd_ch.command);
                check_field("glyph_code", want.glyph_code, cmd_ch.glyph_code);
                check_field("pos_x", want.pos_x, cmd_ch.pos_x);
                check_field("pos_y", want.pos_y, cmd_ch.pos_y);
                check_field("paint_color", want.paint_color, cmd_ch.paint_color);
                check_field("last", want.last, cmd_ch.last);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d commands outstanding",
                     cycle_count, predicted_cmds.size());
            $display("FAIL text_console_cursor_controller_top");
            $finish;
        end
    end

    // Reset, directed characters, then three random phases with different colors.
    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idles little, receiver idles a lot.
        tx_idle_pct = 11;
        rx_idle_pct = 59;

        // Backspace at the first and second cell does nothing, then clears.
        queue_char(CH_BS);
        queue_char(8'h41);
        queue_char(CH_BS);
        queue_char(CH_PRINT_LO);
        queue_char(CH_BS);
        queue_char(CH_PRINT_HI);
        // Ignored codes at the ends of the control and high ranges.
        queue_char(8'h00);
        queue_char(8'h1F);
        queue_char(8'h80);
        queue_char(8'hFF);
        queue_char(CH_CR);
        // Ten tabs from column zero reach the right edge and wrap.
        for (int i = 0; i < 10; i++)
            queue_char(CH_TAB);
        queue_char(8'h5A);
        queue_char(CH_LF);
        queue_text(PHASE_ITEMS);
        wait_drained();

        // Extreme colors; sender idles a lot, receiver little.
        write_colors('0, '1);
        tx_idle_pct = 59;
        rx_idle_pct = 11;
        queue_text(PHASE_ITEMS);
        wait_drained();

        // Random colors, no idling, and one long hold-off on the command side.
        write_colors(COLOR_W'($urandom_range(24'hFFFFFF)),
                     COLOR_W'($urandom_range(24'hFFFFFF)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_request <= 1'b1;
        queue_text(PHASE_ITEMS);
        wait_drained();

        $display("Sent %0d characters, checked %0d commands in %0d cycles.",
                 chars_accepted, cmds_checked, cycle_count);
        $display("Draws %0d, clears %0d, scrolls %0d, draw-then-scroll %0d.",
                 draw_count, clear_count, scroll_count, twin_count);
        if (mismatches == 0)
            $display("PASS text_console_cursor_controller_top");
        else
            $display("FAIL text_console_cursor_controller_top");
        $finish;
    end

endmodule
